// ===== rtl/mh64_pkg.sv =====
package mh64_pkg;

    // Hash constants
    localparam logic [63:0] MUL_M    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL_M_LO = MUL_M[31:0];
    localparam logic [31:0] MUL_M_HI = MUL_M[63:32];
    localparam int unsigned SHIFT_R  = 47;

    // Input tdata layout
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned S_DATA_W = 104;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DECODE,
        ST_MIX1,
        ST_MIX2,
        ST_HMUL,
        ST_FIN,
        ST_DONE
    } state_t;

    // Partial-product steps of the shared multiplier
    typedef enum logic [1:0] {
        PH_LO_LO,
        PH_LO_HI,
        PH_HI_LO
    } mul_phase_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    // Response from the shared multiplier
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    // Keeps the lowest count bytes of a word.
    function automatic logic [63:0] byte_mask(input logic [2:0] count);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < count) begin
                mask[8*i +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

    // x XOR (x >> 47)
    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> SHIFT_R);
    endfunction

endpackage

// ===== rtl/mh64_mul.sv =====
module mh64_mul
    import mh64_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0] a_reg;
    logic [63:0] a_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    mul_phase_t  phase_reg;
    mul_phase_t  phase_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // One 32 x 32 multiplier; the product modulo 2^64 is built from three
    // partial products, the high-by-high term falling outside the result.
    always_comb begin
        mul_a = (phase_reg == PH_HI_LO) ? a_reg[63:32] : a_reg[31:0];
        mul_b = (phase_reg == PH_LO_HI) ? MUL_M_HI : MUL_M_LO;
        prod  = 64'(mul_a) * 64'(mul_b);
    end

    // Step sequencing and accumulation
    always_comb begin
        a_next     = a_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            a_next     = req.operand;
            phase_next = PH_LO_LO;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            case (phase_reg)
                PH_LO_LO: begin
                    acc_next   = prod;
                    phase_next = PH_LO_HI;
                end
                PH_LO_HI: begin
                    acc_next[63:32] = acc_reg[63:32] + prod[31:0];
                    phase_next      = PH_HI_LO;
                end
                PH_HI_LO: begin
                    acc_next[63:32] = acc_reg[63:32] + prod[31:0];
                    busy_next       = 1'b0;
                    done_next       = 1'b1;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Control state is reset; operand and accumulator are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LO_LO;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/murmur_hash_64bit_unit.sv =====
// Each 64-bit multiply by the hash constant is done on the one shared 32 x 32 multiplier.
// A full word takes three multiplies, a partial word one and an empty word none;
// the first word of a message adds one multiply for the length seeding.
// On a last word a final multiply and shift follow the word's own processing before the result is registered.
// Reset (aresetn low, synchronous) clears the sequencer, the message flag and the output
// valid, and sets the seed to zero.
module murmur_hash_64bit_unit
    import mh64_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: hash_seed
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // data_word [63:0], byte_count [67:64], total_length [99:68], zero [103:100]
    input  logic [S_DATA_W-1:0] s_tdata,
    // last_word
    input  logic                s_tlast,
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // hash_value [63:0]
    output logic [63:0]         m_tdata
);

    state_t               state_reg;
    state_t               state_next;
    logic                 in_msg_reg;
    logic                 in_msg_next;
    logic [63:0]          seed_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    word_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 last_reg;
    logic                 last_next;
    logic [63:0]          h_reg;
    logic [63:0]          h_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [63:0]          out_data_reg;
    logic [63:0]          out_data_next;

    logic                 s_accept;
    logic                 out_free;
    logic [LEN_W-1:0]     s_len;
    mul_req_t             mul_req;
    mul_rsp_t             mul_rsp;

    // Shared constant multiplier
    mh64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_len    = s_tdata[WORD_W+COUNT_W +: LEN_W];

    // Sequencer: next state, multiplier requests and datapath updates
    always_comb begin
        state_next      = state_reg;
        in_msg_next     = in_msg_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        h_next          = h_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        mul_req.start   = 1'b0;
        mul_req.operand = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    word_next  = s_tdata[WORD_W-1:0];
                    count_next = s_tdata[WORD_W +: COUNT_W];
                    last_next  = s_tlast;
                    if (!in_msg_reg) begin
                        // Message start: multiply the length by the constant first.
                        mul_req.start   = 1'b1;
                        mul_req.operand = 64'(s_len);
                        in_msg_next     = 1'b1;
                        state_next      = ST_INIT;
                    end else begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_INIT: begin
                if (mul_rsp.done) begin
                    h_next     = seed_reg ^ mul_rsp.product;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (count_reg[3]) begin
                    // Full word, counts above eight included
                    mul_req.start   = 1'b1;
                    mul_req.operand = word_reg;
                    state_next      = ST_MIX1;
                end else if (count_reg[2:0] != 3'd0) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ (word_reg & byte_mask(count_reg[2:0]));
                    state_next      = ST_HMUL;
                end else if (last_reg) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = xor_shift(h_reg);
                    state_next      = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIX1: begin
                if (mul_rsp.done) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = xor_shift(mul_rsp.product);
                    state_next      = ST_MIX2;
                end
            end
            ST_MIX2: begin
                if (mul_rsp.done) begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ mul_rsp.product;
                    state_next      = ST_HMUL;
                end
            end
            ST_HMUL: begin
                if (mul_rsp.done) begin
                    h_next = mul_rsp.product;
                    if (last_reg) begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = xor_shift(mul_rsp.product);
                        state_next      = ST_FIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (mul_rsp.done) begin
                    h_next     = xor_shift(mul_rsp.product);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the finished hash to the output register once it is free.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = h_reg;
                    in_msg_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
        h_reg        <= h_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
